// ===== hdl/signed_modular_alu_unit_macros.svh =====
// assertion macros shared by the signed modular alu rtl
`ifndef SIGNED_MODULAR_ALU_UNIT_MACROS_SVH
`define SIGNED_MODULAR_ALU_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define SMA_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);
`define SMA_ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define SMA_ASSERT_IMP(label, cond, expr, msg)
`define SMA_ASSERT_NXT(label, cond, expr, msg)
`endif

`endif

// ===== hdl/sma_pkg.sv =====
// types, constants and helper functions of the signed modular alu
package sma_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MOD_W      = 31;
    localparam int RED_STAGES = DATA_WIDTH;
    localparam int MUL_STAGES = MOD_W;
    localparam int S_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int ACTION_W   = 2;

    localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(10);

    typedef enum logic [ACTION_W-1:0] {
        ACT_REDUCE = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_MUL    = 2'd2,
        ACT_INC    = 2'd3
    } t_action;

    // restoring reduction of both operand magnitudes, one bit per stage
    typedef struct packed {
        t_action               action;
        logic                  neg_a;
        logic                  neg_b;
        logic [DATA_WIDTH-1:0] mag_a;
        logic [DATA_WIDTH-1:0] mag_b;
        logic [MOD_W-1:0]      rem_a;
        logic [MOD_W-1:0]      rem_b;
    } t_red_stage;

    typedef struct packed {
        logic             is_mul;
        logic             neg;
        logic [MOD_W:0]   sum;
        logic [MOD_W-1:0] rb;
    } t_cmb_stage;

    // modular double-and-add, one multiplier bit per stage
    typedef struct packed {
        logic             is_mul;
        logic             neg;
        logic [MOD_W-1:0] res;
        logic [MOD_W-1:0] ra;
        logic [MOD_W-1:0] rb;
    } t_mul_stage;

    function automatic logic [MOD_W-1:0] red_step(
        input logic [MOD_W-1:0] rem,
        input logic             din,
        input logic [MOD_W-1:0] modulus
    );
        logic [MOD_W:0] shifted;
        logic [MOD_W:0] diff;
        shifted = {rem, din};
        diff    = shifted - {1'b0, modulus};
        if (shifted >= {1'b0, modulus}) begin
            return diff[MOD_W-1:0];
        end
        return shifted[MOD_W-1:0];
    endfunction

endpackage

// ===== hdl/signed_modular_alu_unit.sv =====
// signed modular alu: reduce, add, multiply and increment modulo a programmable modulus
// throughput: one transfer per cycle while the skid register is empty; DATA_WIDTH
// reduction stages, one combine stage and 31 double-and-add stages, then an output
// register backed by a one-entry skid register
// reset: synchronous active-low i_rst_n clears all valid bits and loads the modulus with 10
// the modulus may only be written while no transfer is in flight
`include "signed_modular_alu_unit_macros.svh"

module signed_modular_alu_unit
    import sma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [MOD_W-1:0]      i_cfg_wdata,      // modulus
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // operand_a, operand_b
    input  logic [ACTION_W-1:0]   i_s_axis_tuser,   // action
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata    // residue
);

    logic [MOD_W-1:0] r_modulus;

    logic                  pipe_en;
    logic [DATA_WIDTH-1:0] in_a;
    logic [DATA_WIDTH-1:0] in_b;
    t_red_stage            in_dec;

    t_red_stage             r_red [RED_STAGES];
    logic [RED_STAGES-1:0]  r_red_valid;
    logic [RED_STAGES-1:0]  red_src_valid;

    t_cmb_stage r_cmb;
    logic       r_cmb_valid;
    t_cmb_stage n_cmb;

    t_mul_stage             r_mul [MUL_STAGES];
    logic [MUL_STAGES-1:0]  r_mul_valid;
    logic [MUL_STAGES-1:0]  mul_src_valid;
    t_mul_stage             n_mul_head;

    logic                  last_valid;
    logic [MOD_W-1:0]      last_mag;
    logic                  last_neg;
    logic [DATA_WIDTH-1:0] last_ext;
    logic [DATA_WIDTH-1:0] enc;

    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_data;
    logic                  r_skid_valid;
    logic [DATA_WIDTH-1:0] r_skid_data;

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    // the whole pipeline moves unless the skid register is holding a result
    assign pipe_en         = !r_skid_valid;
    assign o_s_axis_tready = pipe_en;

    assign in_a = i_s_axis_tdata[DATA_WIDTH-1:0];
    assign in_b = i_s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    always_comb begin
        in_dec.action = t_action'(i_s_axis_tuser);
        in_dec.neg_a  = in_a[DATA_WIDTH-1];
        in_dec.neg_b  = in_b[DATA_WIDTH-1];
        in_dec.mag_a  = in_a[DATA_WIDTH-1] ? (~in_a + DATA_WIDTH'(1)) : in_a;
        in_dec.mag_b  = in_b[DATA_WIDTH-1] ? (~in_b + DATA_WIDTH'(1)) : in_b;
        in_dec.rem_a  = '0;
        in_dec.rem_b  = '0;
    end

    // operand reduction, most significant magnitude bit first
    assign red_src_valid = {r_red_valid[RED_STAGES-2:0], i_s_axis_tvalid};

    for (genvar gi = 0; gi < RED_STAGES; gi++) begin : g_red
        t_red_stage src;
        t_red_stage n_red;

        if (gi == 0) begin : g_first
            assign src = in_dec;
        end else begin : g_next
            assign src = r_red[gi-1];
        end

        always_comb begin
            n_red       = src;
            n_red.rem_a = red_step(src.rem_a, src.mag_a[DATA_WIDTH-1-gi], r_modulus);
            n_red.rem_b = red_step(src.rem_b, src.mag_b[DATA_WIDTH-1-gi], r_modulus);
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_red[gi] <= n_red;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_valid <= '0;
        end else if (pipe_en) begin
            r_red_valid <= red_src_valid;
        end
    end

    // first combine stage: signed-magnitude add or increment, multiply setup, reduce pass-through
    always_comb begin
        t_red_stage       rs;
        logic             na;
        logic             nb;
        logic [MOD_W-1:0] opb;
        logic             nopb;
        logic [MOD_W:0]   add_sum;
        logic [MOD_W:0]   diff_ab;
        logic [MOD_W:0]   diff_ba;
        rs      = r_red[RED_STAGES-1];
        na      = rs.neg_a && (rs.rem_a != '0);
        nb      = rs.neg_b && (rs.rem_b != '0);
        opb     = (rs.action == ACT_INC) ? MOD_W'(1) : rs.rem_b;
        nopb    = (rs.action == ACT_INC) ? 1'b0 : nb;
        add_sum = {1'b0, rs.rem_a} + {1'b0, opb};
        diff_ab = {1'b0, rs.rem_a} - {1'b0, opb};
        diff_ba = {1'b0, opb} - {1'b0, rs.rem_a};

        n_cmb.is_mul = 1'b0;
        n_cmb.neg    = na;
        n_cmb.sum    = {1'b0, rs.rem_a};
        n_cmb.rb     = rs.rem_b;
        case (rs.action)
            ACT_ADD, ACT_INC: begin
                if (na == nopb) begin
                    n_cmb.sum = add_sum;
                    n_cmb.neg = na;
                end else if (rs.rem_a >= opb) begin
                    n_cmb.sum = diff_ab;
                    n_cmb.neg = na;
                end else begin
                    n_cmb.sum = diff_ba;
                    n_cmb.neg = nopb;
                end
            end
            ACT_MUL: begin
                n_cmb.is_mul = 1'b1;
                n_cmb.neg    = na ^ nb;
            end
            default: begin
                n_cmb.sum = {1'b0, rs.rem_a};
                n_cmb.neg = na;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_cmb <= n_cmb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmb_valid <= 1'b0;
        end else if (pipe_en) begin
            r_cmb_valid <= r_red_valid[RED_STAGES-1];
        end
    end

    // second combine stage: sum is below twice the modulus, one conditional subtract
    always_comb begin
        logic [MOD_W:0] c2_diff;
        c2_diff           = r_cmb.sum - {1'b0, r_modulus};
        n_mul_head.is_mul = r_cmb.is_mul;
        n_mul_head.neg    = r_cmb.neg;
        n_mul_head.rb     = r_cmb.rb;
        n_mul_head.ra     = r_cmb.sum[MOD_W-1:0];
        if (r_cmb.is_mul) begin
            n_mul_head.res = '0;
        end else if (r_cmb.sum >= {1'b0, r_modulus}) begin
            n_mul_head.res = c2_diff[MOD_W-1:0];
        end else begin
            n_mul_head.res = r_cmb.sum[MOD_W-1:0];
        end
    end

    // modular multiply: acc = (2 * acc + bit * ra) mod n, accumulated value stays below 3n
    assign mul_src_valid = {r_mul_valid[MUL_STAGES-2:0], r_cmb_valid};

    for (genvar gj = 0; gj < MUL_STAGES; gj++) begin : g_mul
        t_mul_stage src;
        t_mul_stage n_mul;

        if (gj == 0) begin : g_first
            assign src = n_mul_head;
        end else begin : g_next
            assign src = r_mul[gj-1];
        end

        always_comb begin
            logic [MOD_W+1:0] acc2;
            logic [MOD_W+1:0] sub2n;
            logic [MOD_W+1:0] sub1n;
            acc2  = {1'b0, src.res, 1'b0}
                  + (src.rb[MOD_W-1-gj] ? {2'b00, src.ra} : '0);
            sub2n = acc2 - {1'b0, r_modulus, 1'b0};
            sub1n = acc2 - {2'b00, r_modulus};
            n_mul = src;
            if (src.is_mul) begin
                if (acc2 >= {1'b0, r_modulus, 1'b0}) begin
                    n_mul.res = sub2n[MOD_W-1:0];
                end else if (acc2 >= {2'b00, r_modulus}) begin
                    n_mul.res = sub1n[MOD_W-1:0];
                end else begin
                    n_mul.res = acc2[MOD_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_mul[gj] <= n_mul;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= '0;
        end else if (pipe_en) begin
            r_mul_valid <= mul_src_valid;
        end
    end

    // sign encode; zero modulus forces a zero result, zero is never negative
    assign last_valid = r_mul_valid[MUL_STAGES-1];
    assign last_mag   = (r_modulus == '0) ? '0 : r_mul[MUL_STAGES-1].res;
    assign last_neg   = r_mul[MUL_STAGES-1].neg && (last_mag != '0);
    assign last_ext   = DATA_WIDTH'(last_mag);
    assign enc        = last_neg ? (~last_ext + DATA_WIDTH'(1)) : last_ext;

    // output register with skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (last_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (last_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_data <= enc;
            end else begin
                r_skid_data <= enc;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_out_data);

    `SMA_ASSERT_IMP(a_skid_implies_out, r_skid_valid, r_out_valid, "skid full with empty output")
    `SMA_ASSERT_NXT(a_skid_holds, r_skid_valid && !i_m_axis_tready, r_skid_valid,
                    "skid result dropped without transfer")
    `SMA_ASSERT_NXT(a_stall_to_skid,
                    r_out_valid && !i_m_axis_tready && last_valid && !r_skid_valid,
                    r_skid_valid, "stalled result not captured in skid")
    `SMA_ASSERT_NXT(a_result_reaches_out, pipe_en && last_valid,
                    r_out_valid, "pipeline result lost at output")

endmodule
